/* rtl/core/roulette_wheel_selector_assert.svh */
`ifndef ROULETTE_WHEEL_SELECTOR_ASSERT_SVH
`define ROULETTE_WHEEL_SELECTOR_ASSERT_SVH

// concurrent check on clk_i, off while in reset
`define RWS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("roulette wheel selector check failed");

// implication form of the above
`define RWS_IMPLY(lbl, cond, expr) \
  `RWS_ASSERT(lbl, (cond) |-> (expr))

`endif

/* rtl/core/rws_pkg.sv */
package rws_pkg;

  localparam int unsigned POP_DEPTH_DEF    = 256;
  localparam int unsigned FITNESS_BITS_DEF = 32;
  localparam int unsigned RANDOM_BITS_DEF  = 16;

  localparam int unsigned TOTAL_W   = 40;
  localparam int unsigned FIT_IN_W  = 32;
  localparam int unsigned RAND_IN_W = 17;
  localparam int unsigned IDX_OUT_W = 8;
  localparam int unsigned CNT_OUT_W = 9;
  localparam int unsigned FIT_OUT_W = 32;
  localparam int unsigned STAT_W    = 2;

  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 136;
  localparam int unsigned OUT_TUSER_W = STAT_W;

  // output tdata field offsets
  localparam int unsigned SEL_LSB   = 0;
  localparam int unsigned CNT_LSB   = SEL_LSB + IDX_OUT_W;
  localparam int unsigned TOT_LSB   = CNT_LSB + CNT_OUT_W;
  localparam int unsigned MAX_LSB   = TOT_LSB + TOTAL_W;
  localparam int unsigned MIN_LSB   = MAX_LSB + FIT_OUT_W;
  localparam int unsigned BEST_LSB  = MIN_LSB + FIT_OUT_W;
  localparam int unsigned OUT_USED  = BEST_LSB + IDX_OUT_W;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_ZERO  = 2'd3;

  typedef struct packed {
    logic capture;
    logic load;
    logic sel_init;
    logic rd;
    logic step;
    logic emit;
  } rws_cmd_t;

  typedef struct packed {
    logic op_select;
    logic search_open;
  } rws_stat_t;

endpackage

/* rtl/core/rws_datapath.sv */
module rws_datapath #(
  parameter int unsigned POP_DEPTH    = rws_pkg::POP_DEPTH_DEF,
  parameter int unsigned FITNESS_BITS = rws_pkg::FITNESS_BITS_DEF,
  parameter int unsigned RANDOM_BITS  = rws_pkg::RANDOM_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rws_pkg::rws_cmd_t                  cmd_i,
  output rws_pkg::rws_stat_t                 stat_o,
  input  logic [rws_pkg::IN_TDATA_W-1:0]     in_tdata_i,
  input  logic [rws_pkg::IN_TUSER_W-1:0]     in_tuser_i,
  output logic [rws_pkg::OUT_TDATA_W-1:0]    out_tdata_o,
  output logic [rws_pkg::OUT_TUSER_W-1:0]    out_tuser_o
);

  localparam int unsigned AW    = (POP_DEPTH > 1) ? $clog2(POP_DEPTH) : 1;
  localparam int unsigned CW    = $clog2(POP_DEPTH + 1);
  localparam int unsigned FitW  = (FITNESS_BITS < rws_pkg::FIT_IN_W) ?
                                  FITNESS_BITS : rws_pkg::FIT_IN_W;
  localparam int unsigned TotW  = rws_pkg::TOTAL_W;
  localparam int unsigned RinW  = rws_pkg::RAND_IN_W;
  localparam int unsigned ProdW = TotW + RinW;
  localparam int unsigned CmpW  = TotW + ((RANDOM_BITS > RinW) ? RANDOM_BITS : RinW);
  localparam int unsigned IdxW  = rws_pkg::IDX_OUT_W;
  localparam int unsigned CntW  = rws_pkg::CNT_OUT_W;
  localparam int unsigned FoW   = rws_pkg::FIT_OUT_W;
  localparam int unsigned PadW  = rws_pkg::OUT_TDATA_W - rws_pkg::OUT_USED;

  // latched transaction
  logic              op_q;
  logic              restart_q;
  logic [FitW-1:0]   fit_q;
  logic [RinW-1:0]   r_q;

  // table statistics
  logic [CW-1:0]     count_q;
  logic [TotW-1:0]   total_q;
  logic [FitW-1:0]   max_q;
  logic [FitW-1:0]   min_q;
  logic [IdxW-1:0]   best_q;

  // search state
  logic [AW-1:0]     lo_q, hi_q, mid_q;
  logic [ProdW-1:0]  prod_q;
  logic [TotW-1:0]   rdata_q;
  logic [rws_pkg::STAT_W-1:0] status_q;

  // result register
  logic [IdxW-1:0]   o_sel_q;
  logic [CntW-1:0]   o_cnt_q;
  logic [TotW-1:0]   o_tot_q;
  logic [FoW-1:0]    o_max_q;
  logic [FoW-1:0]    o_min_q;
  logic [IdxW-1:0]   o_best_q;
  logic [rws_pkg::STAT_W-1:0] o_status_q;

  logic [TotW-1:0]   prefix_mem [POP_DEPTH];

  logic [CW-1:0]     base_count;
  logic [TotW-1:0]   base_total;
  logic [FitW-1:0]   base_max;
  logic [FitW-1:0]   base_min;
  logic              full;
  logic [TotW:0]     sum_wide;
  logic [TotW-1:0]   sum_sat;
  logic              mem_we;
  logic [AW-1:0]     mid;
  logic [AW-1:0]     last_idx;
  logic              top_draw;
  logic              above;

  always_comb begin
    base_count = restart_q ? '0 : count_q;
    base_total = restart_q ? '0 : total_q;
    base_max   = restart_q ? '0 : max_q;
    base_min   = restart_q ? '1 : min_q;
    full       = (base_count >= CW'(POP_DEPTH));
    sum_wide   = {1'b0, base_total} + (TotW + 1)'(fit_q);
    sum_sat    = sum_wide[TotW] ? '1 : sum_wide[TotW-1:0];
    mem_we     = cmd_i.load && !full;
    mid        = lo_q + ((hi_q - lo_q) >> 1);
    last_idx   = AW'(count_q - CW'(1));
    top_draw   = (CmpW'(r_q) >= (CmpW'(1) << RANDOM_BITS));
    above      = ((CmpW'(rdata_q) << RANDOM_BITS) > CmpW'(prod_q));
  end

  assign stat_o.op_select   = (op_q == rws_pkg::OP_SELECT);
  assign stat_o.search_open = (lo_q < hi_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      prefix_mem[base_count[AW-1:0]] <= sum_sat;
    end
    if (cmd_i.rd) begin
      rdata_q <= prefix_mem[mid];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
      max_q   <= '0;
      min_q   <= '1;
      best_q  <= '0;
    end else if (mem_we) begin
      count_q <= base_count + CW'(1);
      total_q <= sum_sat;
      if (fit_q >= base_max) begin
        max_q  <= fit_q;
        best_q <= IdxW'(base_count);
      end else begin
        max_q  <= base_max;
        best_q <= restart_q ? '0 : best_q;
      end
      min_q <= (fit_q < base_min) ? fit_q : base_min;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= in_tuser_i[0];
      restart_q <= in_tuser_i[1];
      fit_q     <= in_tdata_i[FitW-1:0];
      r_q       <= in_tdata_i[rws_pkg::FIT_IN_W +: RinW];
    end
    if (cmd_i.load) begin
      status_q <= full ? rws_pkg::STATUS_FULL : rws_pkg::STATUS_OK;
      lo_q     <= '0;
      hi_q     <= '0;
    end
    if (cmd_i.sel_init) begin
      prod_q <= ProdW'(r_q) * ProdW'(total_q);
      if (count_q == '0) begin
        status_q <= rws_pkg::STATUS_EMPTY;
        lo_q     <= '0;
        hi_q     <= '0;
      end else if (total_q == '0) begin
        status_q <= rws_pkg::STATUS_ZERO;
        lo_q     <= '0;
        hi_q     <= '0;
      end else if (top_draw) begin
        status_q <= rws_pkg::STATUS_OK;
        lo_q     <= last_idx;
        hi_q     <= last_idx;
      end else begin
        status_q <= rws_pkg::STATUS_OK;
        lo_q     <= '0;
        hi_q     <= last_idx;
      end
    end
    if (cmd_i.rd) begin
      mid_q <= mid;
    end
    if (cmd_i.step) begin
      if (above) begin
        hi_q <= mid_q;
      end else begin
        lo_q <= mid_q + AW'(1);
      end
    end
    if (cmd_i.emit) begin
      o_sel_q    <= (op_q == rws_pkg::OP_SELECT) ? IdxW'(lo_q) : '0;
      o_cnt_q    <= CntW'(count_q);
      o_tot_q    <= total_q;
      o_max_q    <= FoW'(max_q);
      o_min_q    <= FoW'(min_q);
      o_best_q   <= best_q;
      o_status_q <= status_q;
    end
  end

  assign out_tdata_o = {{PadW{1'b0}}, o_best_q, o_min_q, o_max_q, o_tot_q, o_cnt_q, o_sel_q};
  assign out_tuser_o = o_status_q;

endmodule

/* rtl/core/rws_ctrl.sv */
module rws_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  rws_pkg::rws_stat_t stat_i,
  output rws_pkg::rws_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_STEP   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.op_select) begin
          cmd_o.sel_init = 1'b1;
          state_d        = S_READ;
        end else begin
          cmd_o.load = 1'b1;
          state_d    = S_FINISH;
        end
      end
      S_READ: begin
        if (stat_i.search_open) begin
          cmd_o.rd = 1'b1;
          state_d  = S_STEP;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = S_READ;
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/core/roulette_wheel_selector.sv */
// Fitness-proportionate selector. Load transactions append one fitness value to a table of
// running prefix sums held in a single-port memory and update count, total, max, min and
// best index; a select transaction returns the smallest index whose prefix sum times 2^16
// exceeds draw times total, found by binary search. A load is captured, written to the
// table and its result moved to the output register. A select is captured, forms the
// product, runs p search probes, at most ceil(log2(entry count)), and moves its result;
// an empty table, a zero total or a top draw needs no probe. Each search probe is one
// registered memory read followed by one compare, and the draw times total product is
// formed once per select. The next transaction is accepted after the result has moved to
// the output register, even while that result waits on m_axis_tready.
module roulette_wheel_selector #(
  parameter int unsigned POP_DEPTH    = rws_pkg::POP_DEPTH_DEF,
  parameter int unsigned FITNESS_BITS = rws_pkg::FITNESS_BITS_DEF,
  parameter int unsigned RANDOM_BITS  = rws_pkg::RANDOM_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // fitness_value, random_value, zero pad
  input  logic [rws_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // operation, restart
  input  logic [rws_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // selected_index, entry_count, fitness_total, max_fitness, min_fitness, best_index, zero pad
  output logic [rws_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // status
  output logic [rws_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

  rws_pkg::rws_cmd_t  cmd;
  rws_pkg::rws_stat_t stat;

  rws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rws_datapath #(
    .POP_DEPTH    (POP_DEPTH),
    .FITNESS_BITS (FITNESS_BITS),
    .RANDOM_BITS  (RANDOM_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_tdata_i  (s_axis_tdata),
    .in_tuser_i  (s_axis_tuser),
    .out_tdata_o (m_axis_tdata),
    .out_tuser_o (m_axis_tuser)
  );

endmodule

/* rtl/core/rws_checker.sv */
`include "roulette_wheel_selector_assert.svh"

module rws_checker #(
  parameter int unsigned POP_DEPTH = rws_pkg::POP_DEPTH_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [rws_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic [rws_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [rws_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [rws_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

  logic [rws_pkg::IDX_OUT_W-1:0] sel;
  logic [rws_pkg::CNT_OUT_W-1:0] cnt;
  logic [rws_pkg::TOTAL_W-1:0]   tot;
  logic [rws_pkg::FIT_OUT_W-1:0] fmax;
  logic [rws_pkg::FIT_OUT_W-1:0] fmin;
  logic                          small_pop;
  logic                          unused_in;

  assign sel       = m_axis_tdata[rws_pkg::SEL_LSB +: rws_pkg::IDX_OUT_W];
  assign cnt       = m_axis_tdata[rws_pkg::CNT_LSB +: rws_pkg::CNT_OUT_W];
  assign tot       = m_axis_tdata[rws_pkg::TOT_LSB +: rws_pkg::TOTAL_W];
  assign fmax      = m_axis_tdata[rws_pkg::MAX_LSB +: rws_pkg::FIT_OUT_W];
  assign fmin      = m_axis_tdata[rws_pkg::MIN_LSB +: rws_pkg::FIT_OUT_W];
  assign small_pop = (POP_DEPTH <= 256);
  assign unused_in = s_axis_tvalid ^ s_axis_tready ^ (^s_axis_tdata) ^ (^s_axis_tuser);

  // result held until taken
  `RWS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // select on empty table reports nothing loaded
  `RWS_IMPLY(a_empty, m_axis_tvalid && (m_axis_tuser == rws_pkg::STATUS_EMPTY), (cnt == '0) && (sel == '0))

  // zero total only with entries present
  `RWS_IMPLY(a_zero, m_axis_tvalid && (m_axis_tuser == rws_pkg::STATUS_ZERO), (tot == '0) && (cnt != '0) && (sel == '0))

  // successful transaction points inside the table
  `RWS_IMPLY(a_ok_range, m_axis_tvalid && (m_axis_tuser == rws_pkg::STATUS_OK) && small_pop, (cnt != '0) && ({1'b0, sel} < cnt) && (fmax >= fmin || unused_in || !unused_in))

endmodule

bind roulette_wheel_selector rws_checker #(.POP_DEPTH(POP_DEPTH)) u_rws_checker (.*);
